// File: src/bxf_pkg.sv
// ----------------------------------------------------------------------------
// bxf_pkg
// Shared types and constants of the 3x3 box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bxf_pkg;

	// line store depth and the widest frame that the column counter covers
	localparam int MAX_WIDTH = 1024;
	localparam int WIDTH_LIM = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int LS_AW     = $clog2(MAX_WIDTH);

	// field and counter widths
	localparam int PIX_W    = 8;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 12;
	localparam int FW_W     = 11;
	localparam int FH_W     = 13;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int HEIGHT_LIM = 4096;

	// sum of nine pixels, and divide by nine as multiply by reciprocal
	localparam int SUM_W     = 12;
	localparam int RECIP_W   = 12;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int RECIP_SH  = 15;
	localparam logic [RECIP_W-1:0] RECIP_9 = 12'd3641;

	// reset values of the configuration registers
	localparam logic [FW_W-1:0] FW_RESET = 11'd512;
	localparam logic [FH_W-1:0] FH_RESET = 13'd512;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// per-pixel tag that travels down the pipeline
	typedef struct packed {
		logic             produce;
		logic             first;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} tag_t;

	// one result item
	typedef struct packed {
		logic [PIX_W-1:0] mean;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] fmax;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

// File: src/bxf_ram.sv
// ----------------------------------------------------------------------------
// bxf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bxf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/box_filter_3x3_mean.sv
// Datapath: after a centre's lower-right pixel transfers, its result passes the
// line store read, 3x3 sum, reciprocal multiply, running max, output register.
// Throughput: one pixel per cycle while the skid stage is empty, set by the
// single read and write port of the packed line store. Border pixels transfer
// in but give no result.
// Reset: counters, running max, handshake state and registers return to their
// reset values at once; the line stores and window are not cleared.
// ----------------------------------------------------------------------------
// box_filter_3x3_mean
// Raster-order 3x3 box mean filter with running frame maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3_mean (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bxf_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [bxf_pkg::DATA_W-1:0]    pwdata,
	output logic      [bxf_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	// pixel input
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bxf_pkg::PIX_W-1:0]     pixel,
	// result output
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [bxf_pkg::PIX_W-1:0]     mean_value,
	output logic      [bxf_pkg::ROW_W-1:0]     center_row,
	output logic      [bxf_pkg::COL_W-1:0]     center_col,
	output logic      [bxf_pkg::PIX_W-1:0]     frame_max,
	output logic                               last_of_frame
);

	import bxf_pkg::*;

	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             adv;
	logic             in_xfer;
	tag_t             tag_in;

	logic             valid_s1;
	tag_t             tag_s1;
	logic [PIX_W-1:0] px_s1;
	logic [2*PIX_W-1:0] ls_rdata;
	logic [PIX_W-1:0] top;
	logic [PIX_W-1:0] mid;
	logic [PIX_W-1:0] win_q [6];
	logic [SUM_W-1:0] sum;

	logic             valid_s2;
	tag_t             tag_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [PROD_W-1:0] prod;

	logic             valid_s3;
	tag_t             tag_s3;
	logic [PIX_W-1:0] mean_s3;

	logic [PIX_W-1:0] max_q;
	logic [PIX_W-1:0] max_base;
	logic [PIX_W-1:0] max_new;
	logic             res_valid;
	result_t          res;

	logic             out_valid_q;
	result_t          out_q;
	logic             skid_valid_q;
	result_t          skid_q;

	// configuration decode, writes complete in the access phase
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// effective frame size, clamped, as last column and last row
	always_comb begin
		if (frame_width_q < FW_W'(3)) begin
			col_last = COL_W'(2);
		end else if (frame_width_q > FW_W'(WIDTH_LIM)) begin
			col_last = COL_W'(WIDTH_LIM - 1);
		end else begin
			col_last = COL_W'(frame_width_q - FW_W'(1));
		end
		if (frame_height_q < FH_W'(3)) begin
			row_last = ROW_W'(2);
		end else if (frame_height_q > FH_W'(HEIGHT_LIM)) begin
			row_last = ROW_W'(HEIGHT_LIM - 1);
		end else begin
			row_last = ROW_W'(frame_height_q - FH_W'(1));
		end
	end

	// pipeline moves while the skid stage is free
	assign adv      = !skid_valid_q;
	assign in_ready = adv;
	assign in_xfer  = in_valid & in_ready;

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_q >= col_last) begin
				col_q <= '0;
				row_q <= (row_q >= row_last) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// tag of the incoming pixel
	always_comb begin
		tag_in.produce = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		tag_in.first   = (row_q == '0) && (col_q == '0);
		tag_in.last    = (row_q == row_last) && (col_q == col_last);
		tag_in.row     = row_q - ROW_W'(1);
		tag_in.col     = col_q - COL_W'(1);
	end

	// stage 1 register: pixel waits for its line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_in;
			px_s1  <= pixel;
		end
	end

	// packed line store: upper byte row above, lower byte two rows above
	bxf_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (valid_s1 & adv),
		.waddr (LS_AW'(tag_s1.col + COL_W'(1))),
		.wdata ({px_s1, mid}),
		.re    (adv),
		.raddr (LS_AW'(col_q)),
		.rdata (ls_rdata)
	);

	assign mid = ls_rdata[2*PIX_W-1:PIX_W];
	assign top = ls_rdata[PIX_W-1:0];

	// window of the two previous columns, shifted on every pixel
	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	// sum of the nine neighbours
	assign sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(px_s1)
		+ SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
		+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);

	// stage 2 and 3 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// divide by nine: reciprocal multiply, exact for sums up to nine full pixels
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP_9);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2  <= tag_s1;
			sum_s2  <= sum;
			tag_s3  <= tag_s2;
			mean_s3 <= prod[RECIP_SH +: PIX_W];
		end
	end

	// running maximum, restarted by the first pixel of a frame
	assign max_base  = tag_s3.first ? '0 : max_q;
	assign max_new   = (tag_s3.produce && mean_s3 > max_base) ? mean_s3 : max_base;
	assign res_valid = valid_s3 & tag_s3.produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (cfg_wr) begin
			max_q <= '0;
		end else if (valid_s3 && adv) begin
			max_q <= max_new;
		end
	end

	always_comb begin
		res.mean = mean_s3;
		res.row  = tag_s3.row;
		res.col  = tag_s3.col;
		res.fmax = max_new;
		res.last = tag_s3.last;
	end

	// output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_ready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_ready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign mean_value    = out_q.mean;
	assign center_row    = out_q.row;
	assign center_col    = out_q.col;
	assign frame_max     = out_q.fmax;
	assign last_of_frame = out_q.last;

	// checks
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full while output register empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid stage filled without an output stall");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= col_last) || $past(cfg_wr))
		else $error("column counter beyond frame width");

	a_center_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.row != '0) && (out_q.col != '0))
		else $error("result for a border centre");

	a_max_covers_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.fmax >= out_q.mean))
		else $error("frame maximum below its own mean");

endmodule

`default_nettype wire
